/* src/scr_pkg.sv */
// shared widths, result type and controller states of the sieve cache
package scr_pkg;

    localparam int KEY_W   = 64;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 5;

    typedef struct packed {
        logic                      hit;
        logic signed [VALUE_W-1:0] read_value;
        logic                      evicted;
        logic        [KEY_W-1:0]   evicted_key;
    } scr_result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_EVICT,
        ST_FREE,
        ST_DONE
    } scr_state_t;

endpackage

/* src/scr_req_if.sv */
// request channel: one lookup or insert item
interface scr_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic        [scr_pkg::KEY_W-1:0]   key;
    logic signed [scr_pkg::VALUE_W-1:0] value;

    modport source (output valid, req_type, key, value, input ready);
    modport sink   (input valid, req_type, key, value, output ready);
endinterface

/* src/scr_rsp_if.sv */
// response channel: one result item per request
interface scr_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic signed [scr_pkg::VALUE_W-1:0] read_value;
    logic                              evicted;
    logic        [scr_pkg::KEY_W-1:0]   evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

/* src/scr_cfg_if.sv */
// configuration write channel for the capacity register
interface scr_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [scr_pkg::CFG_W-1:0]   active_entries;

    modport source (output valid, active_entries, input ready);
    modport sink   (input valid, active_entries, output ready);
endinterface

/* src/scr_slot_ram.sv */
// slot key/value memory, one write port and one registered read port
module scr_slot_ram #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 64,
    parameter int ADDR_W   = 4
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic [KEY_BITS-1:0]          rd_key,
    output logic [scr_pkg::VALUE_W-1:0]  rd_value,
    input  logic                         wr_en,
    input  logic [ADDR_W-1:0]            wr_addr,
    input  logic [KEY_BITS-1:0]          wr_key,
    input  logic [scr_pkg::VALUE_W-1:0]  wr_value
);
    import scr_pkg::*;

    logic [KEY_BITS+VALUE_W-1:0] mem [DEPTH];
    logic [KEY_BITS+VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_value};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_key   = rd_data_reg[KEY_BITS+VALUE_W-1:VALUE_W];
    assign rd_value = rd_data_reg[VALUE_W-1:0];

endmodule

/* src/scr_engine.sv */
// sieve controller: sequential lookup, hand scan, eviction and slot fill
module scr_engine #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64,
    parameter int IDX_W    = 4,
    parameter int CNT_W    = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_req_type,
    input  logic        [scr_pkg::KEY_W-1:0]    in_key,
    input  logic signed [scr_pkg::VALUE_W-1:0]  in_value,
    input  logic                                cfg_we,
    input  logic        [scr_pkg::CFG_W-1:0]    cfg_data,
    output logic                                res_valid,
    input  logic                                res_ready,
    output scr_pkg::scr_result_t                res,
    output logic                                rd_en,
    output logic        [IDX_W-1:0]             rd_addr,
    input  logic        [KEY_BITS-1:0]          rd_key,
    input  logic        [scr_pkg::VALUE_W-1:0]  rd_value,
    output logic                                wr_en,
    output logic        [IDX_W-1:0]             wr_addr,
    output logic        [KEY_BITS-1:0]          wr_key,
    output logic        [scr_pkg::VALUE_W-1:0]  wr_value
);
    import scr_pkg::*;

    scr_state_t            state_reg, state_next;
    logic                  is_ins_reg, is_ins_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]      hand_reg, hand_next;
    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [CNT_W-1:0]      cap_reg, cap_next;
    logic [ENTRIES-1:0]    valid_reg, valid_next;
    logic [ENTRIES-1:0]    visited_reg, visited_next;
    scr_result_t           res_reg, res_next;

    logic                  match;
    logic [CNT_W-1:0]      cap_last;
    logic [CNT_W-1:0]      hand_inc;
    logic [CNT_W-1:0]      pos_inc;
    logic [IDX_W-1:0]      hand_adv;
    logic [IDX_W-1:0]      pos_adv;
    logic [31:0]           cfg_wide;
    logic [CNT_W-1:0]      cap_sat;

    assign match    = cmp_valid_reg && valid_reg[cmp_idx_reg] && (rd_key == key_reg);
    assign cap_last = cap_reg - CNT_W'(1);
    assign hand_inc = CNT_W'(hand_reg) + CNT_W'(1);
    assign pos_inc  = CNT_W'(pos_reg) + CNT_W'(1);
    assign hand_adv = (hand_inc == cap_reg) ? '0 : hand_inc[IDX_W-1:0];
    assign pos_adv  = (pos_inc == cap_reg) ? '0 : pos_inc[IDX_W-1:0];
    assign res      = res_reg;

    // capacity zero acts as one, above the slot count saturates
    always_comb
    begin
        cfg_wide = 32'(cfg_data);
        if (cfg_wide == 32'd0)
        begin
            cap_sat = CNT_W'(1);
        end
        else if (cfg_wide > 32'(ENTRIES))
        begin
            cap_sat = CNT_W'(ENTRIES);
        end
        else
        begin
            cap_sat = cfg_wide[CNT_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        is_ins_next    = is_ins_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        hand_next      = hand_reg;
        pos_next       = pos_reg;
        step_next      = step_reg;
        occ_next       = occ_reg;
        cap_next       = cap_reg;
        valid_next     = valid_reg;
        visited_next   = visited_reg;
        res_next       = res_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg[IDX_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = hand_reg;
        wr_key         = key_reg;
        wr_value       = value_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    is_ins_next = in_req_type;
                    key_next    = in_key[KEY_BITS-1:0];
                    value_next  = in_value;
                    rd_idx_next = '0;
                    if (CNT_W'(hand_reg) >= cap_reg)
                    begin
                        hand_next = '0;
                    end
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // read one slot per cycle, compare the one read last cycle
                rd_en          = (rd_idx_reg < cap_reg);
                cmp_valid_next = rd_en;
                cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (match)
                begin
                    visited_next[cmp_idx_reg] = 1'b1;
                    res_next.hit              = 1'b1;
                    res_next.read_value       = is_ins_reg ? '0 : rd_value;
                    res_next.evicted          = 1'b0;
                    res_next.evicted_key      = '0;
                    if (is_ins_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = cmp_idx_reg;
                    end
                    state_next = ST_DONE;
                end
                else if (cmp_valid_reg && (CNT_W'(cmp_idx_reg) == cap_last))
                begin
                    res_next.hit         = 1'b0;
                    res_next.read_value  = '0;
                    res_next.evicted     = 1'b0;
                    res_next.evicted_key = '0;
                    step_next            = '0;
                    pos_next             = hand_reg;
                    if (!is_ins_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (occ_reg >= cap_reg)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FREE;
                    end
                end
            end
            ST_SCAN:
            begin
                if ((step_reg == cap_reg) || !visited_reg[hand_reg])
                begin
                    rd_en      = 1'b1;
                    rd_addr    = hand_reg;
                    state_next = ST_EVICT;
                end
                else
                begin
                    visited_next[hand_reg] = 1'b0;
                    hand_next              = hand_adv;
                    step_next              = step_reg + CNT_W'(1);
                end
            end
            ST_EVICT:
            begin
                // freed slot is refilled at once, occupancy stays
                res_next.evicted       = valid_reg[hand_reg];
                res_next.evicted_key   = valid_reg[hand_reg] ? KEY_W'(rd_key) : '0;
                wr_en                  = 1'b1;
                wr_addr                = hand_reg;
                valid_next[hand_reg]   = 1'b1;
                visited_next[hand_reg] = 1'b1;
                state_next             = ST_DONE;
            end
            ST_FREE:
            begin
                if (step_reg == cap_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (!valid_reg[pos_reg])
                begin
                    wr_en                 = 1'b1;
                    wr_addr               = pos_reg;
                    valid_next[pos_reg]   = 1'b1;
                    visited_next[pos_reg] = 1'b1;
                    occ_next              = occ_reg + CNT_W'(1);
                    state_next            = ST_DONE;
                end
                else
                begin
                    pos_next  = pos_adv;
                    step_next = step_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // capacity write flushes the cache
        if (cfg_we)
        begin
            cap_next     = cap_sat;
            valid_next   = '0;
            visited_next = '0;
            hand_next    = '0;
            occ_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            hand_reg      <= '0;
            pos_reg       <= '0;
            step_reg      <= '0;
            occ_reg       <= '0;
            cap_reg       <= CNT_W'(ENTRIES);
            valid_reg     <= '0;
            visited_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            hand_reg      <= hand_next;
            pos_reg       <= pos_next;
            step_reg      <= step_next;
            occ_reg       <= occ_next;
            cap_reg       <= cap_next;
            valid_reg     <= valid_next;
            visited_reg   <= visited_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_ins_reg <= is_ins_next;
        key_reg    <= key_next;
        value_reg  <= value_next;
        res_reg    <= res_next;
    end

endmodule

/* src/sieve_cache_replacement_core.sv */
// top level of the sieve replacement key/value cache
//
// req carries one item: req_type (0 get, 1 insert or update), key, value.
// rsp returns one item per request: hit, read_value, evicted, evicted_key.
// cfg writes the capacity (active_entries); a write flushes all slots and
// must come only while no request is in flight.
// a request is taken only when the controller is idle, the cycle after its
// previous result moved to the output register. the lookup compares the
// slots in order and ends at the first match or after the last slot; an
// insert that misses then searches from the hand for a free slot or, on a
// full cache, scans with the hand, clearing visited bits, and evicts the
// first unvisited slot. the lookup reads the slot memory one entry per
// cycle, and the hand scan and free search step one slot per cycle.
// results sit in an output register; while rsp is stalled the controller
// accepts the next request and holds its finished result until the
// register frees up.
// reset empties the cache, parks the hand at slot zero and sets the
// capacity to ENTRIES; slot contents are never cleared, only marked invalid.
module sieve_cache_replacement_core #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    scr_req_if.sink   req,
    scr_rsp_if.source rsp,
    scr_cfg_if.sink   cfg
);
    import scr_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [KEY_BITS-1:0]  rd_key;
    logic [VALUE_W-1:0]   rd_value;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_BITS-1:0]  wr_key;
    logic [VALUE_W-1:0]   wr_value;
    logic                 res_valid;
    logic                 res_ready;
    scr_result_t          res;
    logic                 out_valid_reg;
    scr_result_t          out_reg;

    assign cfg.ready = 1'b1;
    assign res_ready = !out_valid_reg || rsp.ready;

    scr_engine #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .in_req_type (req.req_type),
        .in_key      (req.key),
        .in_value    (req.value),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.active_entries),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_key      (rd_key),
        .rd_value    (rd_value),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_key      (wr_key),
        .wr_value    (wr_value)
    );

    scr_slot_ram #(
        .DEPTH    (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .ADDR_W   (IDX_W)
    ) u_slot_ram (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_value (wr_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_reg.hit;
    assign rsp.read_value  = out_reg.read_value;
    assign rsp.evicted     = out_reg.evicted;
    assign rsp.evicted_key = out_reg.evicted_key;

`ifndef SYNTHESIS
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.hit && rsp.evicted))
        else $error("result reports both hit and eviction");

    a_evkey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.evicted) |-> (rsp.evicted_key == '0))
        else $error("evicted key nonzero without eviction");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.hit) |-> (rsp.read_value == '0))
        else $error("read value nonzero on a miss");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while previous item still in work");
`endif

endmodule
